### rtl/assert_macros.svh
// assertion macros used by the top level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

### rtl/ctp_pkg.sv
// types, constants and the crystal table for the timer period unit
// no dependencies
package ctp_pkg;
  localparam int DW = 29;
  localparam int SW = 24;
  localparam int PW = 7;
  localparam logic [DW-1:0] CLK_PLL = DW'(400000000);
  localparam logic [DW-1:0] CLK_INTERNAL = DW'(16000000);
  localparam logic [DW-1:0] CLK_QUARTER = DW'(4000000);
  localparam logic [DW-1:0] CLK_LOW = DW'(30000);
  localparam logic [PW-1:0] PERIOD_MAX = 7'h7F;
  localparam logic [PW-1:0] PERIOD_MIN = 7'd1;
  localparam logic [2:0] SRC_XTAL = 3'd0;
  localparam logic [2:0] SRC_INT = 3'd1;
  localparam logic [2:0] SRC_QUARTER = 3'd2;
  localparam logic [2:0] SRC_LOW = 3'd3;
  localparam logic REG_PRIMARY = 1'b0;
  localparam logic REG_SECONDARY = 1'b1;

  typedef struct packed {
    logic          valid;
    logic [DW-1:0] rem;
    logic [DW-1:0] num;
    logic [DW-1:0] quo;
    logic [DW-1:0] den;
    logic [DW-1:0] clk_hz;
    logic [SW-1:0] speed;
  } cell_t;

  function automatic logic [DW-1:0] crystal_hz(input logic [4:0] code);
    logic [DW-1:0] hz;
    case (code)
      5'h06: hz = DW'(4000000);
      5'h07: hz = DW'(4096000);
      5'h08: hz = DW'(4915200);
      5'h09: hz = DW'(5000000);
      5'h0A: hz = DW'(5120000);
      5'h0B: hz = DW'(6000000);
      5'h0C: hz = DW'(6144000);
      5'h0D: hz = DW'(7372800);
      5'h0E: hz = DW'(8000000);
      5'h0F: hz = DW'(8192000);
      5'h10: hz = DW'(10000000);
      5'h11: hz = DW'(12000000);
      5'h12: hz = DW'(12288000);
      5'h13: hz = DW'(13560000);
      5'h14: hz = DW'(14318180);
      5'h15: hz = DW'(16000000);
      5'h16: hz = DW'(16384000);
      5'h17: hz = DW'(18000000);
      5'h18: hz = DW'(20000000);
      5'h19: hz = DW'(24000000);
      5'h1A: hz = DW'(25000000);
      default: hz = '0;
    endcase
    return hz;
  endfunction
endpackage

### rtl/ctp_cell.sv
// one restoring divider cell: one quotient bit per cycle while en is high
// depends on ctp_pkg
module ctp_cell import ctp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  cell_t d,
  output cell_t q
);
  logic [DW:0] trial;
  logic        fits;

  always_comb begin
    trial = {d.rem, d.num[DW-1]};
    fits = trial >= {1'b0, d.den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= d.valid;
    end
    if (en) begin
      q.rem <= fits ? DW'(trial - {1'b0, d.den}) : trial[DW-1:0];
      q.num <= {d.num[DW-2:0], 1'b0};
      q.quo <= {d.quo[DW-2:0], fits};
      q.den <= d.den;
      q.clk_hz <= d.clk_hz;
      q.speed <= d.speed;
    end
  end
endmodule

### rtl/ctp_decode.sv
// decodes base clock and divisor from the primary and secondary clock control words
// depends on ctp_pkg
module ctp_decode import ctp_pkg::*; (
  input  logic [31:0]   primary,
  input  logic [31:0]   secondary,
  output logic [DW-1:0] base_hz,
  output logic [7:0]    divisor
);
  logic       alt;
  logic [2:0] src;
  logic       bypass;

  always_comb begin
    alt = secondary[31];
    src = alt ? secondary[6:4] : {1'b0, primary[5:4]};
    bypass = alt ? secondary[11] : primary[11];
    case (src)
      SRC_XTAL: base_hz = crystal_hz(primary[10:6]);
      SRC_INT: base_hz = CLK_INTERNAL;
      SRC_QUARTER: base_hz = CLK_QUARTER;
      SRC_LOW: base_hz = CLK_LOW;
      default: base_hz = CLK_INTERNAL;
    endcase
    if (!bypass) begin
      base_hz = CLK_PLL;
    end
    divisor = 8'd1;
    if (alt) begin
      if (secondary[30]) begin
        divisor = {1'b0, secondary[28:23], secondary[22]} + 8'd1;
      end else if (secondary[22]) begin
        divisor = {2'b0, secondary[28:23]} + 8'd1;
      end
    end else if (primary[22]) begin
      divisor = {4'b0, primary[26:23]} + 8'd1;
    end
  end
endmodule

### rtl/clock_tree_to_i2c_timer_period_unit.sv
// top level of the bus timer period unit: two divider cell chains
// depends on ctp_pkg, ctp_cell, ctp_decode, assert_macros.svh
//
// usage:
//   req channel (req_valid/req_ready) carries one word, bus_speed_hz.
//   rsp channel (rsp_valid/rsp_ready) returns system_clock_hz,
//   timer_period and speed_zero_flag for each request word, in order.
//   cfg_we/cfg_index/cfg_data write clock word 0 (primary) or 1
//   (secondary); write only while no request is in flight.
//   the first chain of 29 cells divides the base clock by the divisor,
//   the second chain of 29 cells divides that clock by 20 * speed; each
//   cell yields one quotient bit, then an output register clamps.
//   a request passes the first chain, the second chain and the output register before rsp_valid.
//   throughput is one word per cycle while no result waits untaken; the chains advance as one pipe.
//   when the receiver stalls, the whole pipe holds and req_ready drops
//   only while a result is waiting and not taken.
//   reset clears both clock words and all valid bits.
`include "assert_macros.svh"
module clock_tree_to_i2c_timer_period_unit import ctp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  logic [SW-1:0] bus_speed_hz,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output logic [DW-1:0] system_clock_hz,
  output logic [PW-1:0] timer_period,
  output logic          speed_zero_flag,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [31:0]   cfg_data
);
  logic [31:0]   primary;
  logic [31:0]   secondary;
  logic [DW-1:0] base_hz;
  logic [7:0]    divisor;
  logic          adv;
  cell_t         c1 [DW+1];
  cell_t         c2 [DW+1];
  logic [DW-1:0] q2;
  logic [PW-1:0] period_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      primary <= '0;
      secondary <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_PRIMARY) begin
        primary <= cfg_data;
      end else begin
        secondary <= cfg_data;
      end
    end
  end

  ctp_decode u_decode (
    .primary(primary), .secondary(secondary), .base_hz(base_hz), .divisor(divisor)
  );

  assign adv = !rsp_valid || rsp_ready;
  assign req_ready = adv;

  always_comb begin
    c1[0].valid = req_valid;
    c1[0].rem = '0;
    c1[0].num = base_hz;
    c1[0].quo = '0;
    c1[0].den = {{(DW-8){1'b0}}, divisor};
    c1[0].clk_hz = '0;
    c1[0].speed = bus_speed_hz;
    // second chain divides the divided clock by 20 * speed
    c2[0].valid = c1[DW].valid;
    c2[0].rem = '0;
    c2[0].num = c1[DW].quo;
    c2[0].quo = '0;
    c2[0].den = DW'({c1[DW].speed, 4'b0}) + DW'({c1[DW].speed, 2'b0});
    c2[0].clk_hz = c1[DW].quo;
    c2[0].speed = c1[DW].speed;
  end

  for (genvar i = 0; i < DW; i++) begin : g_chain
    ctp_cell u_c1 (.clk(clk), .rst(rst), .en(adv), .d(c1[i]), .q(c1[i+1]));
    ctp_cell u_c2 (.clk(clk), .rst(rst), .en(adv), .d(c2[i]), .q(c2[i+1]));
  end

  always_comb begin
    q2 = c2[DW].quo;
    if (c2[DW].speed == '0 || q2 == '0 || q2 > DW'(128)) begin
      period_next = PERIOD_MAX;
    end else if (q2 <= DW'(2)) begin
      period_next = PERIOD_MIN;
    end else begin
      period_next = PW'(q2 - DW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= c2[DW].valid;
    end
    if (adv) begin
      system_clock_hz <= c2[DW].clk_hz;
      timer_period <= period_next;
      speed_zero_flag <= c2[DW].speed == '0;
    end
  end

  `ASSERT_IMPLY(a_zero_max, clk, rst, rsp_valid && speed_zero_flag, timer_period == PERIOD_MAX)
  `ASSERT_IMPLY(a_period_nz, clk, rst, rsp_valid, timer_period != '0)
  `ASSERT_IMPLY(a_clk_range, clk, rst, rsp_valid, system_clock_hz <= CLK_PLL)
  `ASSERT_NEXT(a_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(timer_period))
endmodule
